/* sv/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked every cycle outside reset.
`define GAM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication check failed");

// Next-cycle implication checked outside reset.
`define GAM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

// Next-cycle implication that also runs during reset.
`define GAM_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("%m: reset check failed");

`endif

/* sv/gam_pkg.sv */
// Shared types and constants for the gamepad action mapper.
package gam_pkg;

  // Default sizes
  localparam int NUM_BUTTONS_DEF = 21;
  localparam int NUM_AXES_DEF    = 6;

  // Field and register widths
  localparam int BTN_ACT_W  = 63;
  localparam int AXIS_ACT_W = 36;
  localparam int LEVEL_W    = 15;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 63;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BUTTON_ACTIONS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_ACTIONS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENGAGE_LEVEL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_LEVEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_DELAY    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ACTIVE   = 3'd6;

  // Opcodes
  localparam logic [1:0] OP_BUTTON = 2'd0;
  localparam logic [1:0] OP_AXIS   = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  // Repeat phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_DELAY  = 2'd1;
  localparam logic [1:0] PH_REPEAT = 2'd2;

  // Axis positions
  localparam logic [1:0] POS_CENTER = 2'd0;
  localparam logic [1:0] POS_PLUS   = 2'd1;
  localparam logic [1:0] POS_MINUS  = 2'd2;

  // Actions and events
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_RIGHT = 3'd4;  // highest direction code
  localparam logic       EV_PRESS   = 1'b0;
  localparam logic       EV_RELEASE = 1'b1;

  // Result queue depth in requests
  localparam int QDEPTH = 2;

  typedef struct packed {
    logic [BTN_ACT_W-1:0]  button_actions;
    logic [AXIS_ACT_W-1:0] axis_actions;
    logic [LEVEL_W-1:0]    engage_level;
    logic [LEVEL_W-1:0]    release_level;
    logic [TICK_W-1:0]     repeat_delay;
    logic [TICK_W-1:0]     repeat_interval;
    logic                  window_active;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  input_index;
    logic        pressed;
    logic [15:0] axis_value;
  } in_t;

  typedef struct packed {
    logic       key_event;
    logic [2:0] action_code;
    logic       auto_repeat;
  } res_t;

  // Results of one request: one or two
  typedef struct packed {
    logic pair;
    res_t r0;
    res_t r1;
  } entry_t;

endpackage

/* sv/gam_cfg.sv */
// Configuration register file.
module gam_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [gam_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gam_pkg::CFG_DATA_W-1:0]  cfg_data,
  output gam_pkg::cfg_t                   cfg
);
  import gam_pkg::*;

  cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.button_actions  <= 63'd19392181854261;
      cfg_r.axis_actions    <= 36'd1123;
      cfg_r.engage_level    <= 15'd16384;
      cfg_r.release_level   <= 15'd12000;
      cfg_r.repeat_delay    <= 16'd400;
      cfg_r.repeat_interval <= 16'd100;
      cfg_r.window_active   <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BUTTON_ACTIONS:  cfg_r.button_actions  <= cfg_data[BTN_ACT_W-1:0];
        REG_AXIS_ACTIONS:    cfg_r.axis_actions    <= cfg_data[AXIS_ACT_W-1:0];
        REG_ENGAGE_LEVEL:    cfg_r.engage_level    <= cfg_data[LEVEL_W-1:0];
        REG_RELEASE_LEVEL:   cfg_r.release_level   <= cfg_data[LEVEL_W-1:0];
        REG_REPEAT_DELAY:    cfg_r.repeat_delay    <= cfg_data[TICK_W-1:0];
        REG_REPEAT_INTERVAL: cfg_r.repeat_interval <= cfg_data[TICK_W-1:0];
        REG_WINDOW_ACTIVE:   cfg_r.window_active   <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

/* sv/gam_core.sv */
// Input register, mapper state and the single-pass event logic.
module gam_core #(
  parameter int NUM_BUTTONS = gam_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = gam_pkg::NUM_AXES_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  gam_pkg::in_t    in_data,
  input  gam_pkg::cfg_t   cfg,
  input  logic            q_space,
  output logic            q_push,
  output gam_pkg::entry_t q_entry
);
  import gam_pkg::*;

  localparam int BIDX_W = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int AIDX_W = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic              inv_r;
  in_t               in_r;
  logic [1:0]        axis_pos_r [NUM_AXES];
  logic [2:0]        held_r;
  logic [1:0]        phase_r;
  logic [TICK_W-1:0] cnt_r;

  logic              commit;
  logic [2:0]        btn_tab [2**BIDX_W];
  logic [1:0]        pos_tab [2**AIDX_W];
  logic [5:0]        axact_tab [2**AIDX_W];
  logic [BIDX_W-1:0] bidx;
  logic [AIDX_W-1:0] aidx;

  logic [2:0]        held_nxt;
  logic [1:0]        phase_nxt;
  logic [TICK_W-1:0] cnt_nxt;
  logic [1:0]        nres;
  res_t              r0, r1;
  logic              pos_wr, pos_clr;
  logic [1:0]        pos_old, pos_new;
  logic [2:0]        rel_a, prs_a;
  logic [2:0]        act_neg, act_pos;
  logic signed [16:0] v_s, eng_s, rel_s;

  assign commit   = inv_r && q_space;
  assign in_ready = !inv_r || commit;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inv_r <= 1'b0;
    end else if (in_ready) begin
      inv_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Lookup tables padded to a power of two
  always_comb begin
    for (int i = 0; i < 2**BIDX_W; i++) begin
      btn_tab[i] = ACT_NONE;
    end
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      btn_tab[i] = cfg.button_actions[3*i +: 3];
    end
    for (int i = 0; i < 2**AIDX_W; i++) begin
      pos_tab[i]   = POS_CENTER;
      axact_tab[i] = 6'd0;
    end
    for (int i = 0; i < NUM_AXES; i++) begin
      pos_tab[i]   = axis_pos_r[i];
      axact_tab[i] = cfg.axis_actions[6*i +: 6];
    end
  end

  assign bidx    = in_r.input_index[BIDX_W-1:0];
  assign aidx    = in_r.input_index[AIDX_W-1:0];
  assign pos_old = pos_tab[aidx];
  assign act_neg = axact_tab[aidx][2:0];
  assign act_pos = axact_tab[aidx][5:3];

  assign v_s   = {in_r.axis_value[15], in_r.axis_value};
  assign eng_s = {2'b00, cfg.engage_level};
  assign rel_s = {2'b00, cfg.release_level};

  // Event logic: decide release/press actions, then apply in order
  always_comb begin
    held_nxt  = held_r;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    nres      = 2'd0;
    r0        = '0;
    r1        = '0;
    pos_wr    = 1'b0;
    pos_clr   = 1'b0;
    pos_new   = pos_old;
    rel_a     = ACT_NONE;
    prs_a     = ACT_NONE;

    case (in_r.opcode)
      OP_BUTTON: begin
        if (in_r.input_index < 5'(NUM_BUTTONS)) begin
          if (in_r.pressed) prs_a = btn_tab[bidx];
          else              rel_a = btn_tab[bidx];
        end
      end
      OP_AXIS: begin
        if (in_r.input_index < 5'(NUM_AXES)) begin
          case (pos_old)
            POS_CENTER: begin
              if (v_s >= eng_s)       pos_new = POS_PLUS;
              else if (v_s <= -eng_s) pos_new = POS_MINUS;
            end
            POS_PLUS: begin
              if (v_s < rel_s) pos_new = (v_s <= -eng_s) ? POS_MINUS : POS_CENTER;
            end
            POS_MINUS: begin
              if (v_s > -rel_s) pos_new = (v_s >= eng_s) ? POS_PLUS : POS_CENTER;
            end
            default: ;
          endcase
          if (pos_new != pos_old) begin
            pos_wr = 1'b1;
            if (pos_old == POS_MINUS)     rel_a = act_neg;
            else if (pos_old == POS_PLUS) rel_a = act_pos;
            if (pos_new == POS_MINUS)     prs_a = act_neg;
            else if (pos_new == POS_PLUS) prs_a = act_pos;
          end
        end
      end
      OP_TICK: begin
        if (phase_r != PH_IDLE && held_r != ACT_NONE) begin
          if (cnt_r > 16'd1) begin
            cnt_nxt = cnt_r - 16'd1;
          end else begin
            r0        = '{key_event: EV_PRESS, action_code: held_r, auto_repeat: 1'b1};
            nres      = 2'd1;
            phase_nxt = PH_REPEAT;
            cnt_nxt   = cfg.repeat_interval;
          end
        end
      end
      OP_REMOVE: begin
        rel_a   = held_r;
        pos_clr = 1'b1;
      end
      default: ;
    endcase

    // Release always goes first
    if (rel_a != ACT_NONE) begin
      if (held_nxt == rel_a) begin
        held_nxt  = ACT_NONE;
        phase_nxt = PH_IDLE;
        cnt_nxt   = '0;
      end
      if (cfg.window_active) begin
        r0   = '{key_event: EV_RELEASE, action_code: rel_a, auto_repeat: 1'b0};
        nres = 2'd1;
      end
    end

    // Press; a direction becomes the held one
    if (prs_a != ACT_NONE) begin
      if (nres == 2'd0) r0 = '{key_event: EV_PRESS, action_code: prs_a, auto_repeat: 1'b0};
      else              r1 = '{key_event: EV_PRESS, action_code: prs_a, auto_repeat: 1'b0};
      nres = nres + 2'd1;
      if (prs_a <= ACT_RIGHT) begin
        held_nxt  = prs_a;
        phase_nxt = PH_DELAY;
        cnt_nxt   = cfg.repeat_delay;
      end
    end
  end

  assign q_push        = commit && (nres != 2'd0);
  assign q_entry.pair  = (nres == 2'd2);
  assign q_entry.r0    = r0;
  assign q_entry.r1    = r1;

  // Repeat state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= ACT_NONE;
      phase_r <= PH_IDLE;
      cnt_r   <= '0;
    end else if (commit) begin
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Axis positions
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_AXES; i++) begin
      if (!rst_n || (commit && pos_clr)) begin
        axis_pos_r[i] <= POS_CENTER;
      end else if (commit && pos_wr && aidx == AIDX_W'(i)) begin
        axis_pos_r[i] <= pos_new;
      end
    end
  end

endmodule

/* sv/gam_resq.sv */
// Result queue: holds the results of each request and hands them out one result at a time.
module gam_resq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_push,
  input  gam_pkg::entry_t q_entry,
  output logic            q_space,
  output logic            out_valid,
  input  logic            out_ready,
  output gam_pkg::res_t   out_res,
  output logic            out_last
);
  import gam_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  entry_t        ent_r [QDEPTH];
  logic [PW-1:0] wptr_r, rptr_r;
  logic [PW:0]   count_r;
  logic          sub_r;
  entry_t        head;
  logic          take, pop;

  assign head      = ent_r[rptr_r];
  assign out_valid = (count_r != '0);
  assign q_space   = (count_r < (PW+1)'(QDEPTH));
  assign out_last  = !head.pair || sub_r;
  assign out_res   = sub_r ? head.r1 : head.r0;
  assign take      = out_valid && out_ready;
  assign pop       = take && out_last;

  // Entry storage
  always_ff @(posedge clk) begin
    if (q_push) begin
      ent_r[wptr_r] <= q_entry;
    end
  end

  // Pointers, fill level and position within a pair
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
      sub_r   <= 1'b0;
    end else begin
      if (q_push) wptr_r <= (wptr_r == PW'(QDEPTH-1)) ? '0 : wptr_r + 1'b1;
      if (pop)    rptr_r <= (rptr_r == PW'(QDEPTH-1)) ? '0 : rptr_r + 1'b1;
      count_r <= count_r + (PW+1)'(q_push) - (PW+1)'(pop);
      if (take)   sub_r <= !out_last;
    end
  end

endmodule

/* sv/gamepad_action_mapper_with_repeat.sv */
// Top level of the gamepad action mapper with held-direction repeat.
//
//   channel | direction | handshake               | payload
//   in_     | input     | in_valid / in_ready     | opcode, input_index, pressed, axis_value
//   out_    | output    | out_valid / out_ready   | key_event, action_code, auto_repeat,
//           |           |                         | last_of_run
//   cfg_    | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// A request is taken into the input register, evaluated there and its one or
// two results land in a two-entry result queue once it has space; the first result
// is offered from the queue after the request has passed the input register.
// One request per cycle is sustained while the queue has space; a request with two
// results offers them one after the other on the output port, which slows the rate.
// Synchronous active-low reset returns config to defaults, centers every axis and
// clears the repeat state. Output stalls back up through the queue to in_ready.
module gamepad_action_mapper_with_repeat #(
  parameter int NUM_BUTTONS = gam_pkg::NUM_BUTTONS_DEF,
  parameter int NUM_AXES    = gam_pkg::NUM_AXES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_opcode,
  input  logic [4:0]                     in_input_index,
  input  logic                           in_pressed,
  input  logic signed [15:0]             in_axis_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_key_event,
  output logic [2:0]                     out_action_code,
  output logic                           out_auto_repeat,
  output logic                           out_last_of_run,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gam_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gam_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gam_pkg::*;

  cfg_t   cfg;
  in_t    in_data;
  logic   q_space, q_push;
  entry_t q_entry;
  res_t   out_res;

  assign in_data.opcode      = in_opcode;
  assign in_data.input_index = in_input_index;
  assign in_data.pressed     = in_pressed;
  assign in_data.axis_value  = in_axis_value;

  gam_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gam_core #(
    .NUM_BUTTONS (NUM_BUTTONS),
    .NUM_AXES    (NUM_AXES)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .cfg      (cfg),
    .q_space  (q_space),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  gam_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_entry   (q_entry),
    .q_space   (q_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res),
    .out_last  (out_last_of_run)
  );

  assign out_key_event   = out_res.key_event;
  assign out_action_code = out_res.action_code;
  assign out_auto_repeat = out_res.auto_repeat;

endmodule

/* sv/gam_chk.sv */
// Port-level checker for the mapper, bound to the top level.
`include "assert_macros.svh"

module gam_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_key_event,
  input logic [2:0] out_action_code,
  input logic       out_auto_repeat,
  input logic       out_last_of_run
);
  import gam_pkg::*;

  // Reset empties the result side
  `GAM_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid)

  // Every result names a real action
  `GAM_ASSERT_IMP(a_code_bound, clk, rst_n, out_valid, out_action_code != ACT_NONE)

  // Repeats are presses of a direction and end their run
  `GAM_ASSERT_IMP(a_repeat_dir, clk, rst_n, out_valid && out_auto_repeat, out_key_event == EV_PRESS && out_action_code <= ACT_RIGHT && out_last_of_run)

  // A stalled result holds
  `GAM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_action_code) && $stable(out_key_event) && $stable(out_last_of_run))

endmodule

bind gamepad_action_mapper_with_repeat gam_chk u_gam_chk (.*);

/* sim/mapper_check_pkg.sv */
// Scoreboard class for the gamepad action mapper testbench.
package mapper_check_pkg;
  import gam_pkg::*;

  // One action event as it leaves the block
  typedef struct packed {
    logic       key_event;
    logic [2:0] action_code;
    logic       auto_repeat;
    logic       last_of_run;
  } action_evt_t;

  class action_scoreboard;
    // Shadow copy of the configuration registers
    logic [BTN_ACT_W-1:0]  btn_map;
    logic [AXIS_ACT_W-1:0] axis_map;
    logic [LEVEL_W-1:0]    eng_level;
    logic [LEVEL_W-1:0]    rel_level;
    logic [TICK_W-1:0]     delay_ticks;
    logic [TICK_W-1:0]     interval_ticks;
    logic                  window_on;

    // Shadow copy of the mapper state
    logic [1:0]            axis_pos [NUM_AXES_DEF];
    logic [2:0]            held_dir;
    logic [1:0]            rpt_phase;
    logic [TICK_W-1:0]     rpt_count;

    action_evt_t           run_q[$];        // events of the request being evaluated
    action_evt_t           action_queue[$]; // events still owed by the block
    int                    errors;

    function new();
      btn_map        = 63'd19392181854261;
      axis_map       = 36'd1123;
      eng_level      = 15'd16384;
      rel_level      = 15'd12000;
      delay_ticks    = 16'd400;
      interval_ticks = 16'd100;
      window_on      = 1'b1;
      foreach (axis_pos[i]) axis_pos[i] = POS_CENTER;
      held_dir  = ACT_NONE;
      rpt_phase = PH_IDLE;
      rpt_count = '0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BUTTON_ACTIONS:  btn_map        = data[BTN_ACT_W-1:0];
        REG_AXIS_ACTIONS:    axis_map       = data[AXIS_ACT_W-1:0];
        REG_ENGAGE_LEVEL:    eng_level      = data[LEVEL_W-1:0];
        REG_RELEASE_LEVEL:   rel_level      = data[LEVEL_W-1:0];
        REG_REPEAT_DELAY:    delay_ticks    = data[TICK_W-1:0];
        REG_REPEAT_INTERVAL: interval_ticks = data[TICK_W-1:0];
        REG_WINDOW_ACTIVE:   window_on      = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return action_queue.size();
    endfunction

    // At most two events per request
    function void add_event(logic ev, logic [2:0] code, logic rep);
      action_evt_t e;
      if (run_q.size() >= 2) return;
      e.key_event   = ev;
      e.action_code = code;
      e.auto_repeat = rep;
      e.last_of_run = 1'b0;
      run_q.push_back(e);
    endfunction

    // Press always goes out; a direction becomes the held one
    function void press_act(logic [2:0] a);
      if (a == ACT_NONE) return;
      add_event(EV_PRESS, a, 1'b0);
      if (a <= ACT_RIGHT) begin
        held_dir  = a;
        rpt_phase = PH_DELAY;
        rpt_count = delay_ticks;
      end
    endfunction

    // State clears regardless of window; the event only when active
    function void release_act(logic [2:0] a);
      if (a == ACT_NONE) return;
      if (held_dir == a) begin
        held_dir  = ACT_NONE;
        rpt_phase = PH_IDLE;
        rpt_count = '0;
      end
      if (window_on) add_event(EV_RELEASE, a, 1'b0);
    endfunction

    // A zero count fires on the first tick, same as one
    function void tick_once();
      if (rpt_phase == PH_IDLE || held_dir == ACT_NONE) return;
      if (rpt_count > 16'd1) begin
        rpt_count = rpt_count - 16'd1;
        return;
      end
      add_event(EV_PRESS, held_dir, 1'b1);
      rpt_phase = PH_REPEAT;
      rpt_count = interval_ticks;
    endfunction

    // Three-state axis with engage and release hysteresis
    function void axis_motion(int unsigned ax, logic signed [15:0] raw);
      int         v;
      int         eng;
      int         rel;
      logic [1:0] old_p;
      logic [1:0] new_p;
      logic [2:0] neg_a;
      logic [2:0] pos_a;
      if (ax >= NUM_AXES_DEF) return;
      v     = raw;
      eng   = eng_level;
      rel   = rel_level;
      neg_a = axis_map[6*ax +: 3];
      pos_a = axis_map[6*ax+3 +: 3];
      old_p = axis_pos[ax];
      new_p = old_p;
      case (old_p)
        POS_CENTER: begin
          if (v >= eng) new_p = POS_PLUS;
          else if (v <= -eng) new_p = POS_MINUS;
        end
        POS_PLUS: begin
          if (v < rel) new_p = (v <= -eng) ? POS_MINUS : POS_CENTER;
        end
        default: begin
          if (v > -rel) new_p = (v >= eng) ? POS_PLUS : POS_CENTER;
        end
      endcase
      if (new_p == old_p) return;
      axis_pos[ax] = new_p;
      if (old_p != POS_CENTER) release_act((old_p == POS_MINUS) ? neg_a : pos_a);
      if (new_p != POS_CENTER) press_act((new_p == POS_MINUS) ? neg_a : pos_a);
    endfunction

    // Accepted request: work out its events and queue them
    function void note_request(logic [1:0] op, logic [4:0] idx, logic pr,
                               logic signed [15:0] val);
      int unsigned bi;
      logic [2:0]  a;
      run_q.delete();
      bi = idx;
      case (op)
        OP_BUTTON: begin
          if (bi < NUM_BUTTONS_DEF) begin
            a = btn_map[3*bi +: 3];
            if (a != ACT_NONE) begin
              if (pr) press_act(a);
              else release_act(a);
            end
          end
        end
        OP_AXIS: axis_motion(bi, val);
        OP_TICK: tick_once();
        default: begin
          if (held_dir != ACT_NONE) release_act(held_dir);
          foreach (axis_pos[i]) axis_pos[i] = POS_CENTER;
        end
      endcase
      if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
      foreach (run_q[i]) action_queue.push_back(run_q[i]);
    endfunction

    function void report(string field, logic [3:0] want, logic [3:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // Compare one event from the block with the oldest one owed
    function void check_result(action_evt_t got);
      action_evt_t want;
      if (action_queue.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual ev=%0d act=%0d rep=%0d last=%0d",
                 $time, got.key_event, got.action_code, got.auto_repeat, got.last_of_run);
        return;
      end
      want = action_queue.pop_front();
      if (got.key_event !== want.key_event)
        report("key_event", {3'b0, want.key_event}, {3'b0, got.key_event});
      if (got.action_code !== want.action_code)
        report("action_code", {1'b0, want.action_code}, {1'b0, got.action_code});
      if (got.auto_repeat !== want.auto_repeat)
        report("auto_repeat", {3'b0, want.auto_repeat}, {3'b0, got.auto_repeat});
      if (got.last_of_run !== want.last_of_run)
        report("last_of_run", {3'b0, want.last_of_run}, {3'b0, got.last_of_run});
    endfunction
  endclass

endpackage

/* sim/tb_top.sv */
// Top-level testbench for the gamepad action mapper with held-direction repeat.
module tb_top;
  import gam_pkg::*;
  import mapper_check_pkg::*;

  localparam int RUN_LIMIT       = 400000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_CYCLES     = 100;
  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 240;

  logic                  clk             = 1'b0;
  logic                  rst_n           = 1'b0;
  logic                  in_valid        = 1'b0;
  logic                  in_ready;
  logic [1:0]            in_opcode       = OP_TICK;
  logic [4:0]            in_input_index  = '0;
  logic                  in_pressed      = 1'b0;
  logic signed [15:0]    in_axis_value   = '0;
  logic                  out_valid;
  logic                  out_ready       = 1'b1;
  logic                  out_key_event;
  logic [2:0]            out_action_code;
  logic                  out_auto_repeat;
  logic                  out_last_of_run;
  logic                  cfg_valid       = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index       = '0;
  logic [CFG_DATA_W-1:0] cfg_data        = '0;

  action_scoreboard      sb;
  logic [CFG_DATA_W-1:0] cfg_vals [REG_WINDOW_ACTIVE+1];
  int unsigned           cycles     = 0;
  bit                    tx_idle_en = 1'b1;
  bit                    rx_idle_en = 1'b1;
  bit                    hold_req   = 1'b0;

  gamepad_action_mapper_with_repeat u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_input_index  (in_input_index),
    .in_pressed      (in_pressed),
    .in_axis_value   (in_axis_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_key_event   (out_key_event),
    .out_action_code (out_action_code),
    .out_auto_repeat (out_auto_repeat),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  // Clock, period 10
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result({out_key_event, out_action_code, out_auto_repeat, out_last_of_run});
  end

  // Receiver: random stall bursts, plus one long hold-off on demand
  initial begin : rx_side
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req  = 1'b0;
        out_ready = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 4) == 0) begin
        out_ready = 1'b0;
        n = $urandom_range(1, 7);
        repeat (n) @(negedge clk);
        out_ready = 1'b1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Offer one request; valid stays high into the next one unless idling
  task automatic send_request(input logic [1:0] op, input logic [4:0] idx,
                              input logic pr, input logic [15:0] val);
    int n;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid = 1'b0;
      n = $urandom_range(1, 7);
      repeat (n) @(negedge clk);
    end
    in_opcode      = op;
    in_input_index = idx;
    in_pressed     = pr;
    in_axis_value  = val;
    in_valid       = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(op, idx, pr, val);
    @(negedge clk);
  endtask

  // Stop sending and wait for every owed event, then let the pipe empty
  task automatic settle();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write all registers from cfg_vals, valid held across the burst
  task automatic apply_settings();
    for (int r = REG_BUTTON_ACTIONS; r <= REG_WINDOW_ACTIVE; r++) begin
      cfg_index = r[CFG_IDX_W-1:0];
      cfg_data  = cfg_vals[r];
      cfg_valid = 1'b1;
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      sb.write_reg(cfg_index, cfg_data);
      @(negedge clk);
    end
    cfg_valid = 1'b0;
  endtask

  // Mostly well-formed traffic: valid indexes, values near the thresholds
  task automatic send_random();
    logic [1:0]  op;
    logic [4:0]  idx;
    logic        pr;
    logic [15:0] val;
    int          pick;
    int          mag;
    pick = $urandom_range(0, 99);
    idx  = 5'($urandom);
    pr   = 1'($urandom);
    val  = 16'($urandom);
    if (pick < 30) begin
      op = OP_TICK;
    end else if (pick < 65) begin
      op = OP_AXIS;
      if ($urandom_range(0, 19) != 0) idx = 5'($urandom_range(0, NUM_AXES_DEF - 1));
      if ($urandom_range(0, 7) != 0) begin
        case ($urandom_range(0, 6))
          0:       mag = sb.eng_level;
          1:       mag = int'(sb.eng_level) - 1;
          2:       mag = sb.rel_level;
          3:       mag = int'(sb.rel_level) - 1;
          4:       mag = int'(sb.rel_level) + 1;
          5:       mag = 32767;
          default: mag = $urandom_range(0, 32767);
        endcase
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        if ($urandom_range(0, 1) == 1) mag = -mag;
        if ($urandom_range(0, 15) == 0) mag = -32768;
        val = 16'(mag);
      end
    end else if (pick < 95) begin
      op = OP_BUTTON;
      if ($urandom_range(0, 19) != 0) idx = 5'($urandom_range(0, NUM_BUTTONS_DEF - 1));
    end else begin
      op = OP_REMOVE;
    end
    send_request(op, idx, pr, val);
  endtask

  initial begin : main_seq
    logic [63:0] wide;
    int          eng;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: edge buttons, bad indexes, swing, hold and remove
    send_request(OP_BUTTON, 5'd0,  1'b1, 16'h0000);
    send_request(OP_BUTTON, 5'd0,  1'b0, 16'hFFFF);
    send_request(OP_BUTTON, 5'd20, 1'b1, 16'h0000);
    send_request(OP_BUTTON, 5'd20, 1'b0, 16'h0000);
    send_request(OP_BUTTON, 5'd21, 1'b1, 16'h0000);
    send_request(OP_BUTTON, 5'd31, 1'b1, 16'h0000);
    send_request(OP_AXIS,   5'd0,  1'b0, 16'(32767));
    send_request(OP_TICK,   5'd31, 1'b1, 16'hFFFF);
    send_request(OP_AXIS,   5'd0,  1'b0, 16'(-32768));
    send_request(OP_AXIS,   5'd0,  1'b0, 16'(-12000));
    send_request(OP_AXIS,   5'd0,  1'b1, 16'(-11999));
    send_request(OP_AXIS,   5'd7,  1'b0, 16'(32767));
    send_request(OP_AXIS,   5'd6,  1'b0, 16'(-32768));
    send_request(OP_AXIS,   5'd1,  1'b0, 16'(16384));
    send_request(OP_REMOVE, 5'd0,  1'b0, 16'h0000);
    send_request(OP_AXIS,   5'd5,  1'b0, 16'(-16384));
    send_request(OP_TICK,   5'd0,  1'b0, 16'h0000);
    settle();

    // Zero delay and interval, window inactive
    cfg_vals[REG_BUTTON_ACTIONS]  = 63'd19392181854261;
    cfg_vals[REG_AXIS_ACTIONS]    = 63'd1123;
    cfg_vals[REG_ENGAGE_LEVEL]    = 63'd16384;
    cfg_vals[REG_RELEASE_LEVEL]   = 63'd12000;
    cfg_vals[REG_REPEAT_DELAY]    = '0;
    cfg_vals[REG_REPEAT_INTERVAL] = '0;
    cfg_vals[REG_WINDOW_ACTIVE]   = '0;
    apply_settings();
    send_request(OP_AXIS,   5'd0, 1'b0, 16'(20000));
    send_request(OP_TICK,   5'd0, 1'b0, 16'h0000);
    send_request(OP_TICK,   5'd0, 1'b0, 16'h0000);
    send_request(OP_BUTTON, 5'd0, 1'b1, 16'h0000);
    send_request(OP_BUTTON, 5'd0, 1'b0, 16'h0000);
    send_request(OP_AXIS,   5'd0, 1'b0, 16'h0000);
    send_request(OP_AXIS,   5'd1, 1'b0, 16'(-20000));
    send_request(OP_REMOVE, 5'd0, 1'b0, 16'h0000);
    send_request(OP_TICK,   5'd0, 1'b0, 16'h0000);

    // Random phases, each under its own settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      case (p)
        0: begin
          cfg_vals[REG_BUTTON_ACTIONS]  = '1;
          cfg_vals[REG_AXIS_ACTIONS]    = '0;
          cfg_vals[REG_ENGAGE_LEVEL]    = '0;
          cfg_vals[REG_RELEASE_LEVEL]   = '0;
          cfg_vals[REG_REPEAT_DELAY]    = 63'd1;
          cfg_vals[REG_REPEAT_INTERVAL] = 63'd1;
          cfg_vals[REG_WINDOW_ACTIVE]   = '0;
        end
        1: begin
          cfg_vals[REG_BUTTON_ACTIONS]  = '0;
          cfg_vals[REG_AXIS_ACTIONS]    = 63'hF_FFFF_FFFF;
          cfg_vals[REG_ENGAGE_LEVEL]    = 63'd32767;
          cfg_vals[REG_RELEASE_LEVEL]   = 63'd32767;
          cfg_vals[REG_REPEAT_DELAY]    = 63'd65535;
          cfg_vals[REG_REPEAT_INTERVAL] = 63'd65535;
          cfg_vals[REG_WINDOW_ACTIVE]   = 63'd1;
        end
        default: begin
          wide = {$urandom, $urandom};
          cfg_vals[REG_BUTTON_ACTIONS]  = wide[62:0];
          wide = {$urandom, $urandom};
          cfg_vals[REG_AXIS_ACTIONS]    = {27'd0, wide[35:0]};
          eng = $urandom_range(1000, 32767);
          cfg_vals[REG_ENGAGE_LEVEL]    = 63'(eng);
          // release above engage now and then
          if ($urandom_range(0, 3) == 0)
            cfg_vals[REG_RELEASE_LEVEL] = 63'($urandom_range(0, 32767));
          else
            cfg_vals[REG_RELEASE_LEVEL] = 63'($urandom_range(0, eng));
          cfg_vals[REG_REPEAT_DELAY]    = 63'($urandom_range(1, 12));
          cfg_vals[REG_REPEAT_INTERVAL] = 63'($urandom_range(1, 6));
          cfg_vals[REG_WINDOW_ACTIVE]   = 63'($urandom_range(0, 3) != 0);
        end
      endcase
      apply_settings();
      tx_idle_en = (p != 2) && (p != NUM_PHASES - 1);
      rx_idle_en = (p != 2) && (p != NUM_PHASES - 1);
      // long receiver hold-off while the sender keeps pushing
      if (p == 3) hold_req = 1'b1;
      repeat (ITEMS_PER_PHASE) send_random();
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/gam_pkg.sv
sv/gam_cfg.sv
sv/gam_core.sv
sv/gam_resq.sv
sv/gamepad_action_mapper_with_repeat.sv
sv/gam_chk.sv
sim/mapper_check_pkg.sv
sim/tb_top.sv
